/* hdl/hsim_pkg.sv */
// ----------------------------------------------------------------------------
// hsim_pkg
// Types and constants shared by the hash set intersection matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package hsim_pkg;

  localparam int unsigned TableEntries = 4096;
  localparam int unsigned AddrW        = $clog2(TableEntries);
  localparam int unsigned StepW        = AddrW + 1;
  localparam int unsigned KeyW         = 64;
  localparam int unsigned IdxW         = 12;
  localparam int unsigned InDataW      = 144;
  localparam int unsigned OutDataW     = 24;
  localparam int unsigned QueueDepth   = 2;

  typedef enum logic [1:0] {
    CmdClear  = 2'd0,
    CmdInsert = 2'd1,
    CmdProbe  = 2'd2,
    CmdNop    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StDone  = 2'd0,
    StMatch = 2'd1,
    StFull  = 2'd2,
    StDup   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    BkIdle,
    BkClear,
    BkRead,
    BkCheck,
    BkResp
  } back_state_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [KeyW-1:0]  key_lo;
    logic [KeyW-1:0]  key_hi;
    logic [IdxW-1:0]  idx;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [IdxW-1:0]  index_a;
    logic [IdxW-1:0]  index_b;
  } res_t;

endpackage

`default_nettype wire

/* hdl/hsim_front.sv */
// ----------------------------------------------------------------------------
// hsim_front
// Accepts requests, decodes the command and holds them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module hsim_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    in_cmd_i,
  input  wire logic [hsim_pkg::InDataW-1:0]  in_data_i,
  output logic                               q_valid_o,
  input  wire logic                          q_pop_i,
  output hsim_pkg::req_t                     q_req_o
);

  hsim_pkg::req_t mem_q [hsim_pkg::QueueDepth];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           push, pop;
  hsim_pkg::req_t req_in;

  assign in_ready_o = (cnt_q != 2'(hsim_pkg::QueueDepth));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_req_o    = mem_q[rd_ptr_q];

  always_comb begin
    req_in.cmd    = hsim_pkg::cmd_e'(in_cmd_i);
    req_in.key_lo = in_data_i[hsim_pkg::KeyW-1:0];
    req_in.key_hi = in_data_i[2*hsim_pkg::KeyW-1:hsim_pkg::KeyW];
    req_in.idx    = in_data_i[2*hsim_pkg::KeyW+hsim_pkg::IdxW-1:2*hsim_pkg::KeyW];
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= req_in;
    end
  end

endmodule

`default_nettype wire

/* hdl/hsim_back.sv */
// ----------------------------------------------------------------------------
// hsim_back
// Walks the linear probe chain in table memory and builds one result per request.
// ----------------------------------------------------------------------------
`default_nettype none

module hsim_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_valid_i,
  output logic                 q_pop_o,
  input  wire hsim_pkg::req_t  q_req_i,
  output logic                 res_valid_o,
  input  wire logic            res_ready_i,
  output hsim_pkg::res_t       res_o
);

  localparam logic [hsim_pkg::AddrW-1:0] LastAddr = hsim_pkg::AddrW'(hsim_pkg::TableEntries - 1);
  localparam logic [hsim_pkg::StepW-1:0] LastStep = hsim_pkg::StepW'(hsim_pkg::TableEntries - 1);

  logic [2*hsim_pkg::KeyW-1:0] key_mem [hsim_pkg::TableEntries];
  logic [hsim_pkg::IdxW-1:0]   idx_mem [hsim_pkg::TableEntries];
  logic                        vld_mem [hsim_pkg::TableEntries];

  hsim_pkg::back_state_e       state_q, state_d;
  logic [hsim_pkg::AddrW-1:0]  addr_q, addr_d;
  logic [hsim_pkg::StepW-1:0]  steps_q, steps_d;
  logic                        clr_cmd_q, clr_cmd_d;
  hsim_pkg::req_t              req_q, req_d;
  hsim_pkg::res_t              res_q, res_d;

  logic [2*hsim_pkg::KeyW-1:0] rd_key_q;
  logic [hsim_pkg::IdxW-1:0]   rd_idx_q;
  logic                        rd_vld_q;
  logic                        key_hit;

  logic                        tbl_wr;
  logic                        vld_wr;
  logic                        vld_wdata;

  assign key_hit = (rd_key_q == {req_q.key_hi, req_q.key_lo});

  always_comb begin
    state_d   = state_q;
    addr_d    = addr_q;
    steps_d   = steps_q;
    clr_cmd_d = clr_cmd_q;
    req_d     = req_q;
    res_d     = res_q;
    unique case (state_q)
      hsim_pkg::BkIdle: begin
        if (q_valid_i) begin
          req_d   = q_req_i;
          res_d   = '{status: hsim_pkg::StDone, index_a: '0, index_b: '0};
          addr_d  = q_req_i.key_lo[hsim_pkg::AddrW-1:0];
          steps_d = '0;
          unique case (q_req_i.cmd)
            hsim_pkg::CmdClear: begin
              addr_d    = '0;
              clr_cmd_d = 1'b1;
              state_d   = hsim_pkg::BkClear;
            end
            hsim_pkg::CmdInsert, hsim_pkg::CmdProbe: state_d = hsim_pkg::BkRead;
            default: state_d = hsim_pkg::BkResp;
          endcase
        end
      end
      hsim_pkg::BkClear: begin
        addr_d = addr_q + hsim_pkg::AddrW'(1);
        if (addr_q == LastAddr) begin
          state_d = clr_cmd_q ? hsim_pkg::BkResp : hsim_pkg::BkIdle;
        end
      end
      hsim_pkg::BkRead: begin
        state_d = hsim_pkg::BkCheck;
      end
      hsim_pkg::BkCheck: begin
        priority if (!rd_vld_q) begin
          state_d = hsim_pkg::BkResp;
        end else if (key_hit) begin
          state_d = hsim_pkg::BkResp;
          if (req_q.cmd == hsim_pkg::CmdInsert) begin
            res_d.status = hsim_pkg::StDup;
          end else begin
            res_d = '{status: hsim_pkg::StMatch, index_a: rd_idx_q, index_b: req_q.idx};
          end
        end else if (steps_q == LastStep) begin
          state_d = hsim_pkg::BkResp;
          if (req_q.cmd == hsim_pkg::CmdInsert) begin
            res_d.status = hsim_pkg::StFull;
          end
        end else begin
          steps_d = steps_q + hsim_pkg::StepW'(1);
          addr_d  = addr_q + hsim_pkg::AddrW'(1);
          state_d = hsim_pkg::BkRead;
        end
      end
      hsim_pkg::BkResp: begin
        if (res_ready_i) begin
          state_d = hsim_pkg::BkIdle;
        end
      end
      default: state_d = hsim_pkg::BkIdle;
    endcase
  end

  always_comb begin
    q_pop_o     = (state_q == hsim_pkg::BkIdle);
    res_valid_o = (state_q == hsim_pkg::BkResp);
    res_o       = res_q;
    tbl_wr      = (state_q == hsim_pkg::BkCheck) && !rd_vld_q
                  && (req_q.cmd == hsim_pkg::CmdInsert);
    vld_wr      = tbl_wr || (state_q == hsim_pkg::BkClear);
    vld_wdata   = tbl_wr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= hsim_pkg::BkClear;
      addr_q    <= '0;
      steps_q   <= '0;
      clr_cmd_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      addr_q    <= addr_d;
      steps_q   <= steps_d;
      clr_cmd_q <= clr_cmd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    rd_key_q <= key_mem[addr_q];
    rd_idx_q <= idx_mem[addr_q];
    if (tbl_wr) begin
      key_mem[addr_q] <= {req_q.key_hi, req_q.key_lo};
      idx_mem[addr_q] <= req_q.idx;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_vld_q <= vld_mem[addr_q];
    if (vld_wr) begin
      vld_mem[addr_q] <= vld_wdata;
    end
  end

endmodule

`default_nettype wire

/* hdl/hash_set_intersection_matcher.sv */
// ----------------------------------------------------------------------------
// hash_set_intersection_matcher
// Open-addressed hash table for 128-bit keys: clear, insert set-A, probe set-B.
// ----------------------------------------------------------------------------
//  channel  direction  tdata (low bit up)                 tuser
//  s_axis   in         key_low, key_high, item_index      command
//  m_axis   out        index_a, index_b                   status
//
//  Insert/probe: each slot visited in the probe chain costs one registered
//  memory read and one compare. Clear walks one slot per cycle; no-op goes
//  straight to the response. After reset a clearing pass over all 4096 slots
//  of the valid memory runs; requests queue meanwhile. A 2-entry queue and
//  the output register absorb stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module hash_set_intersection_matcher (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [hsim_pkg::InDataW-1:0]  s_axis_tdata,   // key_low, key_high, item_index
  input  wire logic [1:0]                    s_axis_tuser,   // command
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [hsim_pkg::OutDataW-1:0]      m_axis_tdata,   // index_a, index_b
  output logic [1:0]                         m_axis_tuser    // status
);

  logic           q_valid, q_pop;
  hsim_pkg::req_t q_req;
  logic           res_valid, res_ready;
  hsim_pkg::res_t res;
  logic           out_vld_q;
  hsim_pkg::res_t out_q;

  hsim_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_cmd_i   (s_axis_tuser),
    .in_data_i  (s_axis_tdata),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_req_o    (q_req)
  );

  hsim_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_req_i     (q_req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_ready) begin
      out_vld_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.index_b, out_q.index_a};
  assign m_axis_tuser  = out_q.status;

endmodule

`default_nettype wire
